// File: rtl/core/spu_pkg.sv
// ----------------------------------------------------------------------------
// spu_pkg: shared types, constants and tables of the synaptic plasticity unit
// Holds fixed-point formats, rule codes, register indexes and the exp ROM.
// ----------------------------------------------------------------------------
package spu_pkg;

	// fixed-point formats
	localparam int FRACTION_BITS   = 12;
	localparam int RATE_BITS       = 12;
	localparam int Q30             = 30;
	localparam int ACT_W           = 16;
	localparam int WEIGHT_W        = 14;

	// configuration port
	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 15;
	localparam int RULE_W          = 2;
	localparam int RATE_W          = 13;
	localparam int THRESH_W        = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_RULE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RATE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESH = 2'd2;

	typedef enum logic [RULE_W-1:0] {
		RULE_HEBBIAN = 2'd0,
		RULE_STDP    = 2'd1,
		RULE_BCM     = 2'd2,
		RULE_REWARD  = 2'd3
	} rule_t;

	localparam rule_t                RULE_RESET   = RULE_HEBBIAN;
	localparam logic [RATE_W-1:0]    RATE_RESET   = 13'd41;
	localparam logic [THRESH_W-1:0]  THRESH_RESET = 15'd410;

	// timing-dependent rule: amplitudes as Q0.30
	localparam int AMP_W = 24;
	localparam logic [AMP_W-1:0] AMP_PLUS  = 24'd10737418;
	localparam logic [AMP_W-1:0] AMP_MINUS = 24'd12884902;

	// exp table: entry i = exp(-0.8*i/depth) in Q0.30, index = |dt| >> EXP_IDX_SHIFT
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
	localparam int EXP_IDX_SHIFT   = 4 + FRACTION_BITS - EXP_IDX_W;
	localparam int EXP_W           = Q30 + 1;
	localparam logic [63:0] EXP_X_DEN = 64'(5 * EXP_TABLE_DEPTH);

	typedef logic [EXP_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

	// sliding threshold: floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^31
	localparam logic [31:0] RECIP_100   = 32'd2748779070;
	localparam int          RECIP_SHIFT = 38;
	localparam int          SQ_W        = 31;
	localparam int          THETA_Q_W   = 63 - RECIP_SHIFT;

	// internal widths
	localparam int A_W     = 20;
	localparam int D_W     = 17;
	localparam int AD_W    = A_W + D_W;
	localparam int B_W     = 25;
	localparam int AE_W    = 25;
	localparam int M_W     = 33;
	localparam int X_W     = M_W + RATE_W + 1;
	localparam int DELTA_W = 26;

	// Build the exp table by truncated Taylor series in Q0.30.
	function automatic exp_rom_t exp_rom_fill();
		exp_rom_t           rom;
		logic [63:0]        xq;
		logic [63:0]        term;
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic               run;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			xq   = ((64'd4 * 64'(i)) << Q30) / EXP_X_DEN;
			term = 64'd1 << Q30;
			acc  = $signed(term);
			run  = 1'b1;
			for (int k = 1; k <= 24; k++) begin
				if (run) begin
					t = (term * xq) >> Q30;
					case (k)
						1:       term = t;
						2:       term = t / 64'd2;
						3:       term = t / 64'd3;
						4:       term = t / 64'd4;
						5:       term = t / 64'd5;
						6:       term = t / 64'd6;
						7:       term = t / 64'd7;
						8:       term = t / 64'd8;
						9:       term = t / 64'd9;
						10:      term = t / 64'd10;
						11:      term = t / 64'd11;
						12:      term = t / 64'd12;
						13:      term = t / 64'd13;
						14:      term = t / 64'd14;
						15:      term = t / 64'd15;
						16:      term = t / 64'd16;
						17:      term = t / 64'd17;
						18:      term = t / 64'd18;
						19:      term = t / 64'd19;
						20:      term = t / 64'd20;
						21:      term = t / 64'd21;
						22:      term = t / 64'd22;
						23:      term = t / 64'd23;
						default: term = t / 64'd24;
					endcase
					if (term == 64'd0) begin
						run = 1'b0;
					end else if (k[0]) begin
						acc = acc - $signed(term);
					end else begin
						acc = acc + $signed(term);
					end
				end
			end
			rom[i] = acc[EXP_W-1:0];
		end
		return rom;
	endfunction

endpackage

// File: rtl/core/synaptic_plasticity_update_unit.sv
// ----------------------------------------------------------------------------
// synaptic_plasticity_update_unit: per-synapse weight update pipeline
// Hebbian, timing-dependent, sliding-threshold and reward rules in Q4.12.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the five activity/weight fields and raise start; the
//   item is taken at every rising edge with start high and busy low. busy is
//   always low, so one item enters per clock, back to back.
//   Result channel: upd_weight and weight_changed appear for exactly one cycle
//   with done high, taken from the last pipeline register. The receiver has no
//   way to stall; every item moves down an eight-register pipeline in lock step.
//   Throughput: one item per cycle, as every stage is registered and nothing
//   stalls; every rule takes the same path through the stages.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per edge: the
//   rule (index 0), the rate (index 1) or the threshold (index 2); write only
//   while no item is in flight.
//   Reset: arst_n clears all valid bits and loads the register defaults
//   (Hebbian rule, rate 41, threshold 410). No memory clearing is needed: the
//   exp table is a constant ROM.
// ----------------------------------------------------------------------------
module synaptic_plasticity_update_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [spu_pkg::ACT_W-1:0]     pre_act,
	input  logic signed [spu_pkg::ACT_W-1:0]     post_act,
	input  logic signed [spu_pkg::ACT_W-1:0]     prev_post_act,
	input  logic signed [spu_pkg::WEIGHT_W-1:0]  cur_weight,
	input  logic signed [spu_pkg::ACT_W-1:0]     reward,
	output logic                                 done,
	output logic signed [spu_pkg::WEIGHT_W-1:0]  upd_weight,
	output logic                                 weight_changed,
	input  logic                                 cfg_we,
	input  logic [spu_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [spu_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int FB   = spu_pkg::FRACTION_BITS;
	localparam int AW   = spu_pkg::ACT_W;
	localparam int WW   = spu_pkg::WEIGHT_W;
	localparam int XW   = spu_pkg::X_W;
	localparam int DLW  = spu_pkg::DELTA_W;
	localparam int SUMW = DLW + 1;

	// constant ROM, read once per cycle in stage 2
	localparam spu_pkg::exp_rom_t EXP_ROM = spu_pkg::exp_rom_fill();

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	spu_pkg::rule_t                     rule_q;
	logic [spu_pkg::RATE_W-1:0]         rate_q;
	logic [spu_pkg::THRESH_W-1:0]       thresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= spu_pkg::RULE_RESET;
			rate_q   <= spu_pkg::RATE_RESET;
			thresh_q <= spu_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spu_pkg::REG_RULE:   rule_q   <= spu_pkg::rule_t'(cfg_data[spu_pkg::RULE_W-1:0]);
				spu_pkg::REG_RATE:   rate_q   <= cfg_data[spu_pkg::RATE_W-1:0];
				spu_pkg::REG_THRESH: thresh_q <= cfg_data[spu_pkg::THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// no back pressure anywhere: the pipeline takes an item every cycle
	assign busy = 1'b0;

	// ------------------------------------------------------------------------
	// Valid chain
	// ------------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	// ------------------------------------------------------------------------
	// Stage 1: activity products, post squared, timing difference
	// ------------------------------------------------------------------------
	logic signed [AW-1:0]         mul_a;
	logic signed [2*AW-1:0]       sq_full;
	logic signed [2*AW-1:0]       pa_s1;
	logic [spu_pkg::SQ_W-1:0]     sq_s1;
	logic signed [AW:0]           dt_s1;
	logic signed [AW-1:0]         post_s1;
	logic signed [WW-1:0]         oldw_s1;

	// reward rule reuses the activity multiplier with reward in place of pre
	assign mul_a   = (rule_q == spu_pkg::RULE_REWARD) ? reward : pre_act;
	assign sq_full = post_act * post_act;

	always_ff @(posedge clk) begin
		pa_s1   <= mul_a * post_act;
		sq_s1   <= sq_full[spu_pkg::SQ_W-1:0];
		dt_s1   <= {post_act[AW-1], post_act}
			- {prev_post_act[AW-1], prev_post_act};
		post_s1 <= post_act;
		oldw_s1 <= cur_weight;
	end

	// ------------------------------------------------------------------------
	// Stage 2: post^2/100 by reciprocal, round pre*post, exp ROM lookup
	// ------------------------------------------------------------------------
	logic [spu_pkg::SQ_W-1:0]        sq_bias;
	logic [62:0]                     recip_prod;
	logic signed [2*AW:0]            pa_rnd;
	logic [AW:0]                     adt;
	logic [spu_pkg::EXP_IDX_W-1:0]   exp_idx;

	logic [spu_pkg::THETA_Q_W-1:0]   theta_q_s2;
	logic signed [spu_pkg::A_W-1:0]  a_s2;
	logic signed [2*AW-1:0]          pa_s2;
	logic [spu_pkg::EXP_W-1:0]       e_s2;
	logic                            dneg_s2, dzero_s2;
	logic signed [AW-1:0]            post_s2;
	logic signed [WW-1:0]            oldw_s2;

	// +50 gives the rounded quotient; the sum stays below 2^31
	assign sq_bias    = sq_s1 + spu_pkg::SQ_W'(50);
	assign recip_prod = 63'(sq_bias) * 63'(spu_pkg::RECIP_100);
	// round to nearest, ties away from zero: add half, minus one when negative
	assign pa_rnd     = {pa_s1[2*AW-1], pa_s1} + (2*AW+1)'(1 << (FB - 1))
		- (2*AW+1)'(pa_s1[2*AW-1]);
	assign adt        = dt_s1[AW] ? (AW+1)'(-dt_s1) : (AW+1)'(dt_s1);
	// |dt| never exceeds 65535, so the index always lands inside the table
	assign exp_idx    = adt[spu_pkg::EXP_IDX_SHIFT +: spu_pkg::EXP_IDX_W];

	always_ff @(posedge clk) begin
		theta_q_s2 <= recip_prod[62:spu_pkg::RECIP_SHIFT];
		a_s2       <= pa_rnd[FB +: spu_pkg::A_W];
		pa_s2      <= pa_s1;
		e_s2       <= EXP_ROM[exp_idx];
		dneg_s2    <= dt_s1[AW];
		dzero_s2   <= (dt_s1 == '0);
		post_s2    <= post_s1;
		oldw_s2    <= oldw_s1;
	end

	// ------------------------------------------------------------------------
	// Stage 3: d = post - theta, amplitude times exp entry
	// ------------------------------------------------------------------------
	localparam int DIFF_W = AW + FB + 1;
	localparam int EA_W   = spu_pkg::EXP_W + spu_pkg::AMP_W;

	logic [spu_pkg::THETA_Q_W:0]     theta2;
	logic signed [DIFF_W-1:0]        d_diff;
	logic signed [DIFF_W-1:0]        d_rnd;

	logic signed [spu_pkg::D_W-1:0]  d_s3;
	logic signed [spu_pkg::A_W-1:0]  a_s3;
	logic [EA_W-1:0]                 ea_s3;
	logic signed [2*AW-1:0]          pa_s3;
	logic                            dneg_s3, dzero_s3;
	logic signed [WW-1:0]            oldw_s3;

	// theta at scale ONE^2 is one half plus the rounded post^2/100
	assign theta2 = (spu_pkg::THETA_Q_W+1)'(theta_q_s2)
		+ (spu_pkg::THETA_Q_W+1)'(1 << (2 * FB - 1));
	assign d_diff = $signed({post_s2[AW-1], post_s2, {FB{1'b0}}})
		- $signed(DIFF_W'(theta2));
	assign d_rnd  = d_diff + DIFF_W'(1 << (FB - 1)) - DIFF_W'(d_diff[DIFF_W-1]);

	always_ff @(posedge clk) begin
		d_s3     <= d_rnd[FB +: spu_pkg::D_W];
		a_s3     <= a_s2;
		ea_s3    <= EA_W'(e_s2) * EA_W'(dneg_s2 ? spu_pkg::AMP_MINUS : spu_pkg::AMP_PLUS);
		pa_s3    <= pa_s2;
		dneg_s3  <= dneg_s2;
		dzero_s3 <= dzero_s2;
		oldw_s3  <= oldw_s2;
	end

	// ------------------------------------------------------------------------
	// Stage 4: a*d, round amplitude product to Q0.30
	// ------------------------------------------------------------------------
	logic [EA_W:0]                    ea_rnd;

	logic signed [spu_pkg::AD_W-1:0]  ad_s4;
	logic [spu_pkg::AE_W-1:0]         ae_s4;
	logic signed [2*AW-1:0]           pa_s4;
	logic                             dneg_s4, dzero_s4;
	logic signed [WW-1:0]             oldw_s4;

	assign ea_rnd = (EA_W+1)'(ea_s3) + (EA_W+1)'(1 << (spu_pkg::Q30 - 1));

	always_ff @(posedge clk) begin
		ad_s4    <= a_s3 * d_s3;
		ae_s4    <= ea_rnd[spu_pkg::Q30 +: spu_pkg::AE_W];
		pa_s4    <= pa_s3;
		dneg_s4  <= dneg_s3;
		dzero_s4 <= dzero_s3;
		oldw_s4  <= oldw_s3;
	end

	// ------------------------------------------------------------------------
	// Stage 5: round a*d, pick the operand for the rate multiplier
	// ------------------------------------------------------------------------
	localparam int MW = spu_pkg::M_W;

	logic signed [spu_pkg::AD_W:0]   b_rnd;
	logic signed [spu_pkg::B_W-1:0]  b_val;
	logic signed [MW-1:0]            ae_ext;
	logic signed [MW-1:0]            m_sel;

	logic signed [MW-1:0]            m_s5;
	logic signed [WW-1:0]            oldw_s5;

	assign b_rnd  = {ad_s4[spu_pkg::AD_W-1], ad_s4} + (spu_pkg::AD_W+1)'(1 << (FB - 1))
		- (spu_pkg::AD_W+1)'(ad_s4[spu_pkg::AD_W-1]);
	assign b_val  = b_rnd[FB +: spu_pkg::B_W];
	assign ae_ext = $signed(MW'(ae_s4));

	// a negative timing delta carries its sign into the product; rounding
	// is symmetric, so this matches negating after the final rounding
	always_comb begin
		case (rule_q)
			spu_pkg::RULE_STDP: begin
				if (dzero_s4) begin
					m_sel = '0;
				end else if (dneg_s4) begin
					m_sel = -ae_ext;
				end else begin
					m_sel = ae_ext;
				end
			end
			spu_pkg::RULE_BCM: m_sel = MW'(b_val);
			default:           m_sel = MW'(pa_s4);
		endcase
	end

	always_ff @(posedge clk) begin
		m_s5    <= m_sel;
		oldw_s5 <= oldw_s4;
	end

	// ------------------------------------------------------------------------
	// Stage 6: multiply by the learning rate
	// ------------------------------------------------------------------------
	logic signed [XW-1:0]  x_s6;
	logic signed [WW-1:0]  oldw_s6;

	always_ff @(posedge clk) begin
		x_s6    <= XW'(m_s5) * XW'($signed({1'b0, rate_q}));
		oldw_s6 <= oldw_s5;
	end

	// ------------------------------------------------------------------------
	// Stage 7: round the rate product back to the weight scale
	// ------------------------------------------------------------------------
	localparam int SH_HEBB = FB + spu_pkg::RATE_BITS;
	localparam int SH_STDP = spu_pkg::Q30 + spu_pkg::RATE_BITS - FB;
	localparam int SH_BCM  = spu_pkg::RATE_BITS;

	logic signed [XW:0]     x_ext;
	logic signed [XW:0]     x_hebb, x_stdp, x_bcm;
	logic signed [DLW-1:0]  delta_sel;

	logic signed [DLW-1:0]  delta_s7;
	logic signed [WW-1:0]   oldw_s7;

	// keep the rounded sum signed so the shift fills with the sign bit
	assign x_ext  = {x_s6[XW-1], x_s6};
	assign x_hebb = $signed(x_ext + (XW+1)'(64'd1 << (SH_HEBB - 1))
		- (XW+1)'(x_s6[XW-1])) >>> SH_HEBB;
	assign x_stdp = $signed(x_ext + (XW+1)'(64'd1 << (SH_STDP - 1))
		- (XW+1)'(x_s6[XW-1])) >>> SH_STDP;
	assign x_bcm  = $signed(x_ext + (XW+1)'(64'd1 << (SH_BCM - 1))
		- (XW+1)'(x_s6[XW-1])) >>> SH_BCM;

	always_comb begin
		case (rule_q)
			spu_pkg::RULE_STDP: delta_sel = x_stdp[DLW-1:0];
			spu_pkg::RULE_BCM:  delta_sel = x_bcm[DLW-1:0];
			default:            delta_sel = x_hebb[DLW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		delta_s7 <= delta_sel;
		oldw_s7  <= oldw_s6;
	end

	// ------------------------------------------------------------------------
	// Stage 8: threshold, accumulate, clip to [-1, +1], flag a change
	// ------------------------------------------------------------------------
	localparam logic signed [SUMW-1:0] W_MAX = SUMW'(1 << FB);
	localparam logic signed [SUMW-1:0] W_MIN = -SUMW'(1 << FB);

	logic [DLW-1:0]          delta_mag;
	logic                    delta_keep;
	logic signed [SUMW-1:0]  oldw_ext;
	logic signed [SUMW-1:0]  w_sum;
	logic signed [SUMW-1:0]  w_pick;
	logic signed [WW-1:0]    w_clip;

	logic signed [WW-1:0]    upd_weight_s8;
	logic                    changed_s8;

	assign delta_mag  = delta_s7[DLW-1] ? DLW'(-delta_s7) : DLW'(delta_s7);
	assign delta_keep = delta_mag > DLW'(thresh_q);
	assign oldw_ext   = SUMW'(oldw_s7);
	assign w_sum      = oldw_ext + SUMW'(delta_s7);
	// drop deltas at or below the threshold; an out-of-range old weight is
	// still clipped
	assign w_pick     = delta_keep ? w_sum : oldw_ext;

	always_comb begin
		if (w_pick > W_MAX) begin
			w_clip = W_MAX[WW-1:0];
		end else if (w_pick < W_MIN) begin
			w_clip = W_MIN[WW-1:0];
		end else begin
			w_clip = w_pick[WW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		upd_weight_s8 <= w_clip;
		changed_s8    <= (w_clip != oldw_s7);
	end

	assign done           = vld_s8;
	assign upd_weight     = upd_weight_s8;
	assign weight_changed = changed_s8;

endmodule

// File: test/tb_synaptic_plasticity_update_unit.sv
// ----------------------------------------------------------------------------
// tb_synaptic_plasticity_update_unit: self-checking bench for the plasticity unit
// Walks a short table of corner items under several register settings, then
// streams random synapse items through every rule with random sender gaps.
// Every done pulse is compared with the oldest predicted weight update.
// ----------------------------------------------------------------------------
module tb_synaptic_plasticity_update_unit;

	localparam int ACT_W       = spu_pkg::ACT_W;
	localparam int WEIGHT_W    = spu_pkg::WEIGHT_W;
	localparam int CFG_INDEX_W = spu_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W  = spu_pkg::CFG_DATA_W;

	// fixed-point scales of the update arithmetic
	localparam int     FRAC_Q       = 12;
	localparam int     RATE_Q       = 12;
	localparam int     Q30_BITS     = 30;
	localparam longint ONE_Q        = 64'sd4096;
	localparam int     EXP_DEPTH    = 256;
	// timing-dependent amplitudes, Q0.30 (0.01 potentiation, 0.012 depression)
	localparam longint AMP_POT      = 64'sd10737418;
	localparam longint AMP_DEP      = 64'sd12884902;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

	localparam int PIPE_LATENCY = 7;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int NUM_ROWS     = 24;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 136;
	localparam int QUIET_PHASE  = 6;
	localparam int DRAIN_PHASE  = 3;
	localparam int IDLE_PCT     = 22;

	typedef struct {
		logic signed [ACT_W-1:0]    pre_act;
		logic signed [ACT_W-1:0]    post_act;
		logic signed [ACT_W-1:0]    prev_post_act;
		logic signed [WEIGHT_W-1:0] cur_weight;
		logic signed [ACT_W-1:0]    reward;
	} synapse_item_t;

	typedef struct {
		logic signed [WEIGHT_W-1:0] upd_weight;
		logic                       changed;
	} weight_result_t;

	typedef struct {
		spu_pkg::rule_t rule;
		int             rate;
		int             thresh;
		synapse_item_t  item;
		bit             known;
		weight_result_t result;
	} corner_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [ACT_W-1:0]    pre_act;
	logic signed [ACT_W-1:0]    post_act;
	logic signed [ACT_W-1:0]    prev_post_act;
	logic signed [WEIGHT_W-1:0] cur_weight;
	logic signed [ACT_W-1:0]    reward;
	logic                       done;
	logic signed [WEIGHT_W-1:0] upd_weight;
	logic                       weight_changed;
	logic                       cfg_we;
	logic [CFG_INDEX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	// shadow of the block's registers, updated as they are written
	spu_pkg::rule_t cur_rule   = spu_pkg::RULE_HEBBIAN;
	int             cur_rate   = 41;
	int             cur_thresh = 410;

	longint         exp_q30 [EXP_DEPTH];
	weight_result_t weights_due [$];
	corner_row_t    corner_rows [NUM_ROWS];
	int             mismatches = 0;
	int             cycles = 0;

	synaptic_plasticity_update_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.pre_act        (pre_act),
		.post_act       (post_act),
		.prev_post_act  (prev_post_act),
		.cur_weight     (cur_weight),
		.reward         (reward),
		.done           (done),
		.upd_weight     (upd_weight),
		.weight_changed (weight_changed),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Round to nearest on the magnitude, ties away from zero, then shift down.
	function automatic longint round_shift(longint v, int sh);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	// Predict the weight update of one item under the current register values.
	function automatic weight_result_t plasticity_update(synapse_item_t it);
		weight_result_t r;
		longint pre, post, prev, oldw, rew, rate;
		longint delta, dt, adt, idx, ae, sq, theta2, d, a, b, neww;
		pre   = it.pre_act;
		post  = it.post_act;
		prev  = it.prev_post_act;
		oldw  = it.cur_weight;
		rew   = it.reward;
		rate  = cur_rate;
		delta = 0;
		case (cur_rule)
			spu_pkg::RULE_HEBBIAN: begin
				delta = round_shift(rate * pre * post, FRAC_Q + RATE_Q);
			end
			spu_pkg::RULE_STDP: begin
				// pre is ignored; only the post step sets direction and size
				dt = post - prev;
				if (dt != 0) begin
					adt = (dt < 0) ? -dt : dt;
					idx = (adt * EXP_DEPTH) / (64'sd16 <<< FRAC_Q);
					if (idx > EXP_DEPTH - 1) begin
						idx = EXP_DEPTH - 1;
					end
					ae    = round_shift(exp_q30[idx] * ((dt > 0) ? AMP_POT : AMP_DEP), Q30_BITS);
					delta = round_shift(ae * rate, Q30_BITS + RATE_Q - FRAC_Q);
					if (dt < 0) begin
						delta = -delta;
					end
				end
			end
			spu_pkg::RULE_BCM: begin
				// theta = 0.5 + post^2/100, held at the squared scale
				sq     = post * post;
				theta2 = (64'sd1 <<< (2 * FRAC_Q - 1)) + (sq + 50) / 100;
				d      = round_shift(post * ONE_Q - theta2, FRAC_Q);
				a      = round_shift(pre * post, FRAC_Q);
				b      = round_shift(a * d, FRAC_Q);
				delta  = round_shift(b * rate, RATE_Q);
			end
			default: begin
				delta = round_shift(rate * rew * post, FRAC_Q + RATE_Q);
			end
		endcase
		if (((delta < 0) ? -delta : delta) <= cur_thresh) begin
			delta = 0;
		end
		neww = oldw + delta;
		if (neww > ONE_Q) begin
			neww = ONE_Q;
		end else if (neww < -ONE_Q) begin
			neww = -ONE_Q;
		end
		r.upd_weight = WEIGHT_W'(neww);
		r.changed    = (neww != oldw);
		return r;
	endfunction

	function automatic corner_row_t make_row(spu_pkg::rule_t rule, int rate, int thresh,
			int pre, int post, int prev, int oldw, int rew, bit known, int nw, bit chg);
		corner_row_t r;
		r.rule               = rule;
		r.rate               = rate;
		r.thresh             = thresh;
		r.item.pre_act       = ACT_W'(pre);
		r.item.post_act      = ACT_W'(post);
		r.item.prev_post_act = ACT_W'(prev);
		r.item.cur_weight    = WEIGHT_W'(oldw);
		r.item.reward        = ACT_W'(rew);
		r.known              = known;
		r.result.upd_weight  = WEIGHT_W'(nw);
		r.result.changed     = chg;
		return r;
	endfunction

	// Mix of rails, small values and full-range noise.
	function automatic logic signed [ACT_W-1:0] rand_activity();
		case ($urandom_range(0, 9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3, 4: return ACT_W'(int'($urandom_range(0, 16384)) - 8192);
			default: return ACT_W'($urandom);
		endcase
	endfunction

	function automatic synapse_item_t rand_item(spu_pkg::rule_t rule);
		synapse_item_t it;
		it.pre_act  = rand_activity();
		it.post_act = rand_activity();
		// for the timing rule keep half the post steps short to stress the low exp entries
		if (rule == spu_pkg::RULE_STDP && $urandom_range(0, 1) == 1) begin
			it.prev_post_act = it.post_act
				+ ACT_W'(int'($urandom_range(0, 8000)) - 4000);
		end else begin
			it.prev_post_act = rand_activity();
		end
		if ($urandom_range(0, 99) < 85) begin
			it.cur_weight = WEIGHT_W'(int'($urandom_range(0, 8192)) - 4096);
		end else begin
			it.cur_weight = WEIGHT_W'($urandom);
		end
		if ($urandom_range(0, 99) < 85) begin
			it.reward = ACT_W'(-int'($urandom_range(0, 32768)));
		end else begin
			it.reward = ACT_W'($urandom);
		end
		return it;
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 1;
			2:       return 4096;
			3:       return $urandom_range(1, 4096);
			4:       return $urandom_range(1, 64);
			default: return $urandom_range(0, 8191);
		endcase
	endfunction

	function automatic int pick_thresh();
		case ($urandom_range(0, 5))
			0:       return 0;
			1:       return 32767;
			2:       return $urandom_range(0, 32767);
			default: return $urandom_range(0, 600);
		endcase
	endfunction

	// Present one item, hold it until the block takes it, and log its expected update.
	task automatic drive(synapse_item_t it, bit known, weight_result_t typed);
		start         <= 1'b1;
		pre_act       <= it.pre_act;
		post_act      <= it.post_act;
		prev_post_act <= it.prev_post_act;
		cur_weight    <= it.cur_weight;
		reward        <= it.reward;
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		if (known) begin
			weights_due.push_back(typed);
		end else begin
			weights_due.push_back(plasticity_update(it));
		end
	endtask

	// Drop start for an idle gap and scramble the fields meanwhile.
	task automatic idle(int n);
		synapse_item_t junk;
		junk           = rand_item(cur_rule);
		start         <= 1'b0;
		pre_act       <= junk.pre_act;
		post_act      <= junk.post_act;
		prev_post_act <= junk.prev_post_act;
		cur_weight    <= junk.cur_weight;
		reward        <= junk.reward;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every logged update has come back, plus pipeline slack.
	task automatic settle();
		start <= 1'b0;
		while (weights_due.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// Write all three registers back to back; optionally poke the unused index too.
	task automatic configure(spu_pkg::rule_t rule, int rate, int thresh, bit poke_spare);
		cfg_we    <= 1'b1;
		cfg_index <= spu_pkg::REG_RULE;
		cfg_data  <= CFG_DATA_W'(rule);
		@(posedge clk);
		cfg_index <= spu_pkg::REG_RATE;
		cfg_data  <= CFG_DATA_W'(rate);
		@(posedge clk);
		cfg_index <= spu_pkg::REG_THRESH;
		cfg_data  <= CFG_DATA_W'(thresh);
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= REG_SPARE;
			cfg_data  <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we     <= 1'b0;
		cur_rule   = rule;
		cur_rate   = rate;
		cur_thresh = thresh;
	endtask

	// Build the exp table: truncated Taylor series of exp(-0.8*i/depth) in Q0.30.
	initial begin
		longint unsigned xq;
		longint unsigned term;
		longint          sum;
		bit              live;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			xq   = ((64'd4 * i) << Q30_BITS) / (64'd5 * EXP_DEPTH);
			term = 64'd1 << Q30_BITS;
			sum  = longint'(term);
			live = 1'b1;
			for (int k = 1; k <= 24; k++) begin
				if (live) begin
					term = ((term * xq) >> Q30_BITS) / k;
					if (term == 0) begin
						live = 1'b0;
					end else if (k % 2 == 1) begin
						sum = sum - longint'(term);
					end else begin
						sum = sum + longint'(term);
					end
				end
			end
			exp_q30[i] = sum;
		end
	end

	// Compare every done pulse with the oldest logged update.
	always @(posedge clk) begin
		weight_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (weights_due.size() == 0) begin
				$display("%0t unexpected result: upd_weight %0d weight_changed %0b",
					$time, upd_weight, weight_changed);
				mismatches++;
			end else begin
				want = weights_due.pop_front();
				if (upd_weight !== want.upd_weight) begin
					$display("%0t upd_weight expected %0d actual %0d",
						$time, want.upd_weight, upd_weight);
					mismatches++;
				end
				if (weight_changed !== want.changed) begin
					$display("%0t weight_changed expected %0b actual %0b",
						$time, want.changed, weight_changed);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: fail the run if it hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_synaptic_plasticity_update_unit NOT OK");
			$finish;
		end
	end

	initial begin
		corner_row_t    row;
		synapse_item_t  it;
		spu_pkg::rule_t rule;
		int             rate;
		int             thresh;

		arst_n        = 1'b0;
		start         = 1'b0;
		pre_act       = '0;
		post_act      = '0;
		prev_post_act = '0;
		cur_weight    = '0;
		reward        = '0;
		cfg_we        = 1'b0;
		cfg_index     = spu_pkg::REG_RULE;
		cfg_data      = '0;

		// Corner table. The first rows run on the reset register values on purpose.
		corner_rows[0]  = make_row(spu_pkg::RULE_HEBBIAN, 41, 410, 0, 0, 0, 0, 0, 1, 0, 0);
		// out-of-range old weight: clip even with zero delta, and flag it
		corner_rows[1]  = make_row(spu_pkg::RULE_HEBBIAN, 41, 410, 0, 0, 0, 8191, 0,
			1, 4096, 1);
		corner_rows[2]  = make_row(spu_pkg::RULE_HEBBIAN, 41, 410, 0, 0, 0, -8192, 0,
			1, -4096, 1);
		corner_rows[3]  = make_row(spu_pkg::RULE_HEBBIAN, 41, 410, 32767, 32767, 0, 4096,
			-32768, 0, 0, 0);
		// unbounded delta saturates the sum
		corner_rows[4]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 0, 32767, 32767, 0, 0, 0,
			1, 4096, 1);
		corner_rows[5]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 0, -32768, 32767, 0, 0, 0,
			1, -4096, 1);
		corner_rows[6]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 0, -32768, -32768, 0, -4096,
			0, 1, 4096, 1);
		// delta equal to the threshold is dropped, one above passes
		corner_rows[7]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 410, 4096, 410, 0, 0, 0,
			1, 0, 0);
		corner_rows[8]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 410, 4096, 411, 0, 0, 0,
			1, 411, 1);
		corner_rows[9]  = make_row(spu_pkg::RULE_HEBBIAN, 4096, 410, 4096, -411, 0, 0, 0,
			1, -411, 1);
		// zero learning rate kills every delta
		corner_rows[10] = make_row(spu_pkg::RULE_HEBBIAN, 0, 0, 32767, 32767, 0, 1234, 0,
			1, 1234, 0);
		// timing rule: no step, widest steps both ways, unit steps, a short step at rate 1
		corner_rows[11] = make_row(spu_pkg::RULE_STDP, 4096, 0, 0, 500, 500, 100, 0,
			1, 100, 0);
		corner_rows[12] = make_row(spu_pkg::RULE_STDP, 4096, 0, -1, 32767, -32768, 0, 0,
			0, 0, 0);
		corner_rows[13] = make_row(spu_pkg::RULE_STDP, 4096, 0, -1, -32768, 32767, 0, 0,
			0, 0, 0);
		corner_rows[14] = make_row(spu_pkg::RULE_STDP, 4096, 0, 32767, 1, 0, -4096, 0,
			0, 0, 0);
		corner_rows[15] = make_row(spu_pkg::RULE_STDP, 4096, 0, -32768, 0, 1, 4096, 0,
			0, 0, 0);
		corner_rows[16] = make_row(spu_pkg::RULE_STDP, 1, 0, 1000, 300, 0, 0, 0, 0, 0, 0);
		// sliding threshold at the rails and near theta
		corner_rows[17] = make_row(spu_pkg::RULE_BCM, 4096, 0, 32767, 32767, 0, 0, 0,
			0, 0, 0);
		corner_rows[18] = make_row(spu_pkg::RULE_BCM, 4096, 0, -32768, -32768, 0, 0, 0,
			0, 0, 0);
		corner_rows[19] = make_row(spu_pkg::RULE_BCM, 4096, 0, 4096, 2048, 0, 0, 0, 0, 0, 0);
		// reward rule, reward at both rails taken as is
		corner_rows[20] = make_row(spu_pkg::RULE_REWARD, 4096, 0, 0, 32767, 0, 0, 32767,
			0, 0, 0);
		corner_rows[21] = make_row(spu_pkg::RULE_REWARD, 4096, 0, 0, 32767, 0, 0, -32768,
			0, 0, 0);
		// largest threshold still passed by a rail-to-rail product
		corner_rows[22] = make_row(spu_pkg::RULE_REWARD, 4096, 32767, 0, -32768, 0, 0,
			-32768, 1, 4096, 1);
		corner_rows[23] = make_row(spu_pkg::RULE_REWARD, 4096, 32767, 0, 1, 0, -3, -1,
			0, 0, 0);

		// hold reset, then release it on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the corner table; rewrite registers only when a row asks for new ones.
		for (int n = 0; n < NUM_ROWS; n++) begin
			row = corner_rows[n];
			if (row.rule != cur_rule || row.rate != cur_rate || row.thresh != cur_thresh) begin
				settle();
				configure(row.rule, row.rate, row.thresh, 1'b0);
			end
			if ($urandom_range(0, 99) < IDLE_PCT) begin
				idle($urandom_range(1, 9));
			end
			drive(row.item, row.known, row.result);
		end

		// Random phases: each one picks a register setting, drains, writes it, then streams items.
		for (int p = 0; p < NUM_PHASES; p++) begin
			rule   = (p < 8) ? spu_pkg::rule_t'(p % 4) : spu_pkg::rule_t'($urandom_range(0, 3));
			rate   = (p == 0) ? 4096 : (p == 1) ? 1 : pick_rate();
			thresh = (p == 2) ? 32767 : (p == 3) ? 0 : pick_thresh();
			settle();
			configure(rule, rate, thresh, p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// once mid-stream, stall the sender until the pipe is empty
				if (p == DRAIN_PHASE && n == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					while (weights_due.size() != 0) @(posedge clk);
				end else if (p != QUIET_PHASE && $urandom_range(0, 99) < IDLE_PCT) begin
					idle($urandom_range(1, 9));
				end
				it = rand_item(rule);
				drive(it, 1'b0, '{default: '0});
			end
		end

		// drain and give the pipe time to show any stray result
		start <= 1'b0;
		while (weights_due.size() != 0) @(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_synaptic_plasticity_update_unit OK");
		end else begin
			$display("tb_synaptic_plasticity_update_unit NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/spu_pkg.sv
rtl/core/synaptic_plasticity_update_unit.sv
test/tb_synaptic_plasticity_update_unit.sv
